// ===== hw/rtl/ptw_pkg.sv =====
// Shared types, constants and helper functions for the four-level page table walker.
// No dependencies; every other file of the walker imports this package.
`timescale 1ns / 1ps

package ptw_pkg;

   // Field widths fixed by the item formats.
   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned PA_W    = 52;
   localparam int unsigned END_W   = 53;
   localparam int unsigned SHIFT_W = 6;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned IDX_W   = 9;

   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   // Item classes decided by the front.
   typedef enum logic [1:0] {
      OP_REQUEST     = 2'd0,
      OP_ENTRY_OK    = 2'd1,
      OP_ENTRY_FAULT = 2'd2
   } op_type;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_WINDOW_BASE = 8'd0;
   localparam logic [INDEX_W-1:0] REG_ROOT_TABLE  = 8'd1;

   // Entry bits and masks.
   localparam int unsigned BIT_PRESENT = 0;
   localparam int unsigned BIT_LARGE   = 7;
   localparam logic [ADDR_W-1:0] PHYS_MASK  = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [ADDR_W-1:0] TABLE_MASK = 64'h000F_FFFF_FFFF_F000;

   // Walk level: 0 is the top table (shift 39), 3 is the last (shift 12).
   typedef logic [1:0] level_type;
   localparam level_type TOP_LEVEL  = 2'd0;
   localparam level_type LAST_LEVEL = 2'd3;

   // One queued item: class, large page flag and the address or entry word.
   typedef struct packed {
      op_type            op;
      logic              large_page;
      logic [ADDR_W-1:0] data;
   } item_type;

   // Page shift of a level.
   function automatic logic [SHIFT_W-1:0] level_shift(input level_type level);
      logic [SHIFT_W-1:0] shift;
      unique case (level)
         2'd0:    shift = 6'd39;
         2'd1:    shift = 6'd30;
         2'd2:    shift = 6'd21;
         default: shift = 6'd12;
      endcase
      return shift;
   endfunction

   // Mask of the page offset bits below the shift of a level.
   function automatic logic [ADDR_W-1:0] low_mask(input level_type level);
      logic [ADDR_W-1:0] mask;
      unique case (level)
         2'd0:    mask = 64'h0000_007F_FFFF_FFFF;
         2'd1:    mask = 64'h0000_0000_3FFF_FFFF;
         2'd2:    mask = 64'h0000_0000_001F_FFFF;
         default: mask = 64'h0000_0000_0000_0FFF;
      endcase
      return mask;
   endfunction

   // Nine-bit table index of a virtual address at a level.
   function automatic logic [IDX_W-1:0] table_index(input logic [ADDR_W-1:0] va,
                                                    input level_type level);
      logic [IDX_W-1:0] idx;
      unique case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== hw/rtl/ptw_channels.sv =====
// Channel interfaces of the page table walker: request, response and register write.
// Depends on ptw_pkg for field widths and the result kind type.
`timescale 1ns / 1ps

interface ptw_req_if import ptw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] virtual_address;
   logic [ADDR_W-1:0] entry_data;
   logic              read_error;

   modport source (output valid, func, virtual_address, entry_data, read_error,
                   input ready);
   modport sink   (input valid, func, virtual_address, entry_data, read_error,
                   output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [ADDR_W-1:0]  read_address;
   logic [PA_W-1:0]    physical_address;
   logic [END_W-1:0]   page_end;
   logic [SHIFT_W-1:0] page_shift;

   modport source (output valid, kind, read_address, physical_address, page_end,
                   page_shift, input ready);
   modport sink   (input valid, kind, read_address, physical_address, page_end,
                   page_shift, output ready);
endinterface

interface ptw_csr_if import ptw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [ADDR_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ptw_front.sv =====
// Front end of the walker: accepts request beats, classifies them and queues them.
// Depends on ptw_pkg and the ptw_req_if channel interface.
`timescale 1ns / 1ps

module ptw_front import ptw_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_ch,
   output item_type  q_item,
   output logic      q_valid,
   input  logic      q_pop
);

   localparam int unsigned PTR_W = $clog2(QueueDepth);
   localparam int unsigned CNT_W = $clog2(QueueDepth + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QueueDepth - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QueueDepth);

   item_type         queue_ff [QueueDepth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         classified;
   logic             push;

   // Classify the incoming beat: new request, usable entry or faulting entry.
   always_comb begin
      classified.large_page = req_ch.entry_data[BIT_LARGE];
      if (!req_ch.func) begin
         classified.op   = OP_REQUEST;
         classified.data = req_ch.virtual_address;
      end else begin
         classified.data = req_ch.entry_data;
         if (req_ch.read_error || !req_ch.entry_data[BIT_PRESENT]) begin
            classified.op = OP_ENTRY_FAULT;
         end else begin
            classified.op = OP_ENTRY_OK;
         end
      end
   end

   // Queue handshake.
   assign req_ch.ready = (count_ff != FULL_CNT);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign q_item       = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== hw/rtl/ptw_back.sv =====
// Back end of the walker: configuration registers, walk state and the response register.
// Depends on ptw_pkg and the ptw_rsp_if and ptw_csr_if channel interfaces.
`timescale 1ns / 1ps

module ptw_back import ptw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ptw_csr_if.sink  csr_ch,
   input  item_type q_item,
   input  logic     q_valid,
   output logic     q_pop,
   ptw_rsp_if.source rsp_ch
);

   // Configuration and walk state.
   logic [ADDR_W-1:0] window_ff, window_in;
   logic [ADDR_W-1:0] root_ff, root_in;
   logic              walking_ff, walking_in;
   level_type         level_ff, level_in;
   logic [ADDR_W-1:0] saved_ff, saved_in;
   logic [ADDR_W-1:0] base_ff, base_in;

   // Response register.
   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [ADDR_W-1:0]  out_ra_ff, out_ra_in;
   logic [PA_W-1:0]    out_pa_ff, out_pa_in;
   logic [END_W-1:0]   out_pe_ff, out_pe_in;
   logic [SHIFT_W-1:0] out_ps_ff, out_ps_in;

   // Working signals for the item being executed.
   logic              can_load;
   logic              emit;
   level_type         next_level;
   level_type         rd_level;
   logic [ADDR_W-1:0] rd_base;
   logic [ADDR_W-1:0] rd_va;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] low;
   logic [ADDR_W-1:0] pa_full;
   logic [PA_W-1:0]   pa;
   logic [END_W-1:0]  pe;
   logic              leaf;

   // The response register frees up when empty or when its beat is taken.
   assign can_load = !out_valid_ff || rsp_ch.ready;
   assign q_pop    = q_valid && can_load;

   // Configuration writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      window_in = window_ff;
      root_in   = root_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_WINDOW_BASE: window_in = csr_ch.data;
            REG_ROOT_TABLE:  root_in   = csr_ch.data;
            default: ;
         endcase
      end
   end

   // Table read address: a new walk starts from the root, a descent from the entry.
   assign next_level = level_type'(level_ff + 2'd1);
   assign rd_level   = (q_item.op == OP_REQUEST) ? TOP_LEVEL : next_level;
   assign rd_base    = (q_item.op == OP_REQUEST) ? root_ff : (q_item.data & TABLE_MASK);
   assign rd_va      = (q_item.op == OP_REQUEST) ? q_item.data : saved_ff;
   assign rd_addr    = window_ff + rd_base
                       + {{(ADDR_W - IDX_W - 3){1'b0}}, table_index(rd_va, rd_level), 3'b000};

   // Translation of a leaf entry.
   assign low     = low_mask(level_ff);
   assign pa_full = (q_item.data & PHYS_MASK & ~low) | (saved_ff & low);
   assign pa      = pa_full[PA_W-1:0];
   assign pe      = {1'b0, pa | low[PA_W-1:0]} + END_W'(1);
   assign leaf    = q_item.large_page || (level_ff == LAST_LEVEL);

   // Execute the item at the head of the queue.
   always_comb begin
      walking_in  = walking_ff;
      level_in    = level_ff;
      saved_in    = saved_ff;
      base_in     = base_ff;
      emit        = 1'b0;
      out_kind_in = KIND_READ;
      out_ra_in   = '0;
      out_pa_in   = '0;
      out_pe_in   = '0;
      out_ps_in   = level_shift(level_ff);
      if (q_pop) begin
         case (q_item.op)
            OP_REQUEST: begin
               if (!walking_ff) begin
                  walking_in  = 1'b1;
                  level_in    = TOP_LEVEL;
                  saved_in    = q_item.data;
                  base_in     = root_ff;
                  emit        = 1'b1;
                  out_kind_in = KIND_READ;
                  out_ra_in   = rd_addr;
                  out_ps_in   = level_shift(TOP_LEVEL);
               end
            end
            OP_ENTRY_FAULT: begin
               if (walking_ff) begin
                  walking_in  = 1'b0;
                  level_in    = TOP_LEVEL;
                  emit        = 1'b1;
                  out_kind_in = KIND_FAULT;
               end
            end
            OP_ENTRY_OK: begin
               if (walking_ff) begin
                  emit = 1'b1;
                  if (leaf) begin
                     walking_in  = 1'b0;
                     level_in    = TOP_LEVEL;
                     out_kind_in = KIND_DONE;
                     out_pa_in   = pa;
                     out_pe_in   = pe;
                  end else begin
                     level_in    = next_level;
                     base_in     = rd_base;
                     out_kind_in = KIND_READ;
                     out_ra_in   = rd_addr;
                     out_ps_in   = level_shift(next_level);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign out_valid_in = can_load ? (q_pop && emit) : out_valid_ff;

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         root_ff      <= '0;
         walking_ff   <= 1'b0;
         level_ff     <= TOP_LEVEL;
         out_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         root_ff      <= root_in;
         walking_ff   <= walking_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Walk payload and response payload.
   always_ff @(posedge clock) begin
      saved_ff <= saved_in;
      base_ff  <= base_in;
      if (q_pop && emit) begin
         out_kind_ff <= out_kind_in;
         out_ra_ff   <= out_ra_in;
         out_pa_ff   <= out_pa_in;
         out_pe_ff   <= out_pe_in;
         out_ps_ff   <= out_ps_in;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.kind             = out_kind_ff;
   assign rsp_ch.read_address     = out_ra_ff;
   assign rsp_ch.physical_address = out_pa_ff;
   assign rsp_ch.page_end         = out_pe_ff;
   assign rsp_ch.page_shift       = out_ps_ff;

   // A pending table read belongs to a walk still in progress.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == KIND_READ) |-> walking_ff)
      else $error("table read shown while no walk is active");

   // A finished or faulted walk has returned to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind != KIND_READ) |-> !walking_ff)
      else $error("walk still active after its final beat");

   // The page end lies past the translated address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == KIND_DONE)
         |-> (rsp_ch.page_end > {1'b0, rsp_ch.physical_address}))
      else $error("page end not above physical address");

   // An idle walker sits at the top level.
   assert property (@(posedge clock) disable iff (reset)
      !walking_ff |-> (level_ff == TOP_LEVEL))
      else $error("idle walker not at top level");

endmodule

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Four-level page table walker: top level joining the front queue and the back end.
// Depends on ptw_pkg, the channel interfaces, ptw_front and ptw_back.
//
// Usage: beats on req_ch either start a translation (func 0, virtual_address) or return
// a table entry (func 1, entry_data, read_error). Each accepted beat gives zero or one
// beat on rsp_ch: a table read to issue (kind read, read_address), a finished
// translation (kind done, physical_address, page_end, page_shift) or a fault.
// Beats out of turn (a request during a walk, an entry while idle) give nothing.
// csr_ch writes window_base (index 0) and root_table (index 1); write only while idle.
// An accepted beat passes through the front queue and then the response register before
// its response beat is shown. Throughput is one beat per cycle while the receiver takes
// beats, set by the single response register that the back end reloads when it is free.
// Reset clears both registers, the walk state and the queue; the block is ready as soon
// as reset is released. When the receiver stalls, the response register holds its
// beat, the back end stops draining, and the front queue keeps taking beats until it
// fills (QueueDepth entries), then drops req_ch.ready.
`timescale 1ns / 1ps

module four_level_page_table_walker import ptw_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_ch,
   ptw_rsp_if.source rsp_ch,
   ptw_csr_if.sink   csr_ch
);

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   // Accept and classify beats into the queue.
   ptw_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // Run the walk and drive the response register.
   ptw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
